[hw/rtl/drt_pkg.sv]
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and constants of the DRAM refresh interval timer.
// ----------------------------------------------------------------------------
package drt_pkg;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_WR_CTRL  = 2'd1,
        OP_WR_TC    = 2'd2,
        OP_WR_COUNT = 2'd3
    } op_t;

    // Write keys
    localparam logic [15:0] KEY_BYTE_MASK  = 16'hFF00;
    localparam logic [15:0] KEY_BYTE_VALUE = 16'hA500;
    localparam logic [15:0] KEY_COUNT_MASK  = 16'hFC00;
    localparam logic [15:0] KEY_COUNT_VALUE = 16'hA400;

    // Refresh count limits (11 bits to hold the incremented count)
    localparam logic [10:0] LIMIT_FULL = 11'd1024;
    localparam logic [10:0] LIMIT_HALF = 11'd512;

    // Control byte bit positions
    localparam int CTRL_LIMIT_SEL  = 0;
    localparam int CTRL_OVF_FLAG   = 2;
    localparam int CTRL_MATCH_FLAG = 7;

    // Result of one item
    typedef struct packed {
        logic [7:0] timer_value;
        logic [9:0] count_value;
        logic [7:0] control_value;
        logic       write_accepted;
    } result_t;

endpackage

[hw/rtl/drt_cmd_if.sv]
// ----------------------------------------------------------------------------
// drt_cmd_if
// Command channel: a tick or a keyed register write.
// ----------------------------------------------------------------------------
interface drt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] wdata;

    modport source (output valid, output op, output wdata, input ready);
    modport sink   (input valid, input op, input wdata, output ready);
endinterface

[hw/rtl/drt_status_if.sv]
// ----------------------------------------------------------------------------
// drt_status_if
// Status channel: register values after each command.
// ----------------------------------------------------------------------------
interface drt_status_if;
    logic       valid;
    logic       ready;
    logic [7:0] timer_value;
    logic [9:0] count_value;
    logic [7:0] control_value;
    logic       write_accepted;

    modport source (output valid, output timer_value, output count_value,
                    output control_value, output write_accepted, input ready);
    modport sink   (input valid, input timer_value, input count_value,
                    input control_value, input write_accepted, output ready);
endinterface

[hw/rtl/drt_core.sv]
// ----------------------------------------------------------------------------
// drt_core
// Timer, time constant, refresh count and control registers with their
// combinational update for one command.
// ----------------------------------------------------------------------------
module drt_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [1:0]        op,
    input  logic [15:0]       wdata,
    output drt_pkg::result_t  result
);

    logic [7:0]  timer_reg, timer_next;
    logic [7:0]  tc_reg, tc_next;
    logic [9:0]  count_reg, count_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic        accepted;
    logic [8:0]  timer_inc;
    logic [10:0] count_inc;
    logic [10:0] limit;
    logic        byte_key_ok;
    logic        count_key_ok;

    // Compute the register values after the command
    always_comb
    begin
        timer_next   = timer_reg;
        tc_next      = tc_reg;
        count_next   = count_reg;
        ctrl_next    = ctrl_reg;
        accepted     = 1'b0;
        timer_inc    = {1'b0, timer_reg} + 9'd1;
        count_inc    = {1'b0, count_reg} + 11'd1;
        limit        = ctrl_reg[drt_pkg::CTRL_LIMIT_SEL] ? drt_pkg::LIMIT_HALF
                                                         : drt_pkg::LIMIT_FULL;
        byte_key_ok  = (wdata & drt_pkg::KEY_BYTE_MASK) == drt_pkg::KEY_BYTE_VALUE;
        count_key_ok = (wdata & drt_pkg::KEY_COUNT_MASK) == drt_pkg::KEY_COUNT_VALUE;

        case (drt_pkg::op_t'(op))
            drt_pkg::OP_TICK:
            begin
                if (timer_inc >= {1'b0, tc_reg})
                begin
                    // match: clear timer, set match flag, advance or wrap refresh count
                    timer_next = '0;
                    ctrl_next[drt_pkg::CTRL_MATCH_FLAG] = 1'b1;
                    if (count_inc >= limit)
                    begin
                        count_next = '0;
                        ctrl_next[drt_pkg::CTRL_OVF_FLAG] = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc[9:0];
                    end
                end
                else
                begin
                    timer_next = timer_inc[7:0];
                end
            end
            drt_pkg::OP_WR_CTRL:
            begin
                if (byte_key_ok)
                begin
                    ctrl_next = wdata[7:0];
                    accepted  = 1'b1;
                end
            end
            drt_pkg::OP_WR_TC:
            begin
                if (byte_key_ok)
                begin
                    tc_next  = wdata[7:0];
                    accepted = 1'b1;
                end
            end
            drt_pkg::OP_WR_COUNT:
            begin
                if (count_key_ok)
                begin
                    count_next = wdata[9:0];
                    accepted   = 1'b1;
                end
            end
            default:
            begin
                accepted = 1'b0;
            end
        endcase

        result.timer_value    = timer_next;
        result.count_value    = count_next;
        result.control_value  = ctrl_next;
        result.write_accepted = accepted;
    end

    // Commit the update when the command moves to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            tc_reg    <= '0;
            count_reg <= '0;
            ctrl_reg  <= '0;
        end
        else if (advance)
        begin
            timer_reg <= timer_next;
            tc_reg    <= tc_next;
            count_reg <= count_next;
            ctrl_reg  <= ctrl_next;
        end
    end

endmodule

[hw/rtl/dram_refresh_timer.sv]
// ----------------------------------------------------------------------------
// dram_refresh_timer
// Refresh interval timer with keyed register writes, one status per command.
// ----------------------------------------------------------------------------
// Each command (tick or keyed write) returns one status transfer holding the
// timer, refresh count and control byte after the command, plus whether a
// write key matched. The block takes one command per clock cycle while the
// command side is not stalled; a status appears once the command has passed
// the input register and its result reaches the output register. The register
// update for a command is one step of logic between those registers, so
// back-to-back commands see each other's effect. The command side stalls only
// while the output register holds a status that is not taken in that cycle
// and the input register is full.
module dram_refresh_timer (
    input  logic             clk,
    input  logic             rst_n,
    drt_cmd_if.sink          cmd,
    drt_status_if.source     status
);

    logic              in_valid_reg;
    logic [1:0]        op_reg;
    logic [15:0]       wdata_reg;
    logic              out_valid_reg;
    drt_pkg::result_t  out_reg;
    drt_pkg::result_t  result;
    logic              advance;

    // Move the held command on when the output register is free or its status is taken
    assign advance   = in_valid_reg && (!out_valid_reg || status.ready);
    assign cmd.ready = !in_valid_reg || advance;

    // Hold the accepted command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg    <= cmd.op;
            wdata_reg <= cmd.wdata;
        end
    end

    // Register state and update
    drt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .op      (op_reg),
        .wdata   (wdata_reg),
        .result  (result)
    );

    // Hold the status until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign status.valid          = out_valid_reg;
    assign status.timer_value    = out_reg.timer_value;
    assign status.count_value    = out_reg.count_value;
    assign status.control_value  = out_reg.control_value;
    assign status.write_accepted = out_reg.write_accepted;

endmodule

[sim/tb_dram_refresh_timer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dram_refresh_timer
// Self-checking bench for the DRAM refresh interval timer.
// ----------------------------------------------------------------------------
// Commands go in on the command channel and are mirrored into a shadow copy
// of the timer, time constant, refresh count and control byte. Each accepted
// command queues the status it must produce, and every status transfer is
// checked field by field against the oldest queued one. A short directed
// walk covers keys, limits and flag handling. Random traffic follows, mostly
// ticks and keyed writes with small time constants so that matches and count
// wraps happen often. Both channels idle at random, the status side is held
// off for long stretches, and the command side pauses until the status queue
// has drained.
// ----------------------------------------------------------------------------
module tb_dram_refresh_timer;

    // One row of the directed walk
    typedef struct {
        drt_pkg::op_t     op;
        logic [15:0]      wdata;
        bit               fixed;
        drt_pkg::result_t res;
    } walk_row_t;

    logic clk;
    logic rst_n;

    drt_cmd_if    cmd_ch();
    drt_status_if status_ch();

    dram_refresh_timer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .status (status_ch)
    );

    // Shadow registers of the timer
    logic [7:0] shadow_timer;
    logic [7:0] shadow_tc;
    logic [9:0] shadow_count;
    logic [7:0] shadow_ctrl;

    drt_pkg::result_t pending_status[$];
    walk_row_t        walk[$];

    // Typed-in expectation of the item on the bus
    bit               cur_fixed;
    drt_pkg::result_t cur_res;

    bit         src_idle_on;
    bit         sink_idle_on;
    int         hold_requests;
    int         hold_served;

    int         errors;
    int         n_ticks;
    int         n_keys_ok;
    int         n_keys_bad;
    int         n_wraps;
    int         n_checked;

    // Generate the clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Advance the shadow registers by one command and return the status
    function automatic drt_pkg::result_t advance_refresh(input drt_pkg::op_t op,
                                                         input logic [15:0] wd);
        logic [8:0]       nxt;
        logic [10:0]      cnt_inc;
        logic [10:0]      lim;
        drt_pkg::result_t r;
        r.write_accepted = 1'b0;
        case (op)
            drt_pkg::OP_TICK:
            begin
                n_ticks++;
                nxt = {1'b0, shadow_timer} + 9'd1;
                if (nxt >= {1'b0, shadow_tc})
                begin
                    lim = shadow_ctrl[drt_pkg::CTRL_LIMIT_SEL] ? drt_pkg::LIMIT_HALF
                                                               : drt_pkg::LIMIT_FULL;
                    cnt_inc = {1'b0, shadow_count} + 11'd1;
                    shadow_timer = 8'd0;
                    shadow_ctrl[drt_pkg::CTRL_MATCH_FLAG] = 1'b1;
                    if (cnt_inc >= lim)
                    begin
                        cnt_inc = 11'd0;
                        shadow_ctrl[drt_pkg::CTRL_OVF_FLAG] = 1'b1;
                        n_wraps++;
                    end
                    shadow_count = cnt_inc[9:0];
                end
                else
                begin
                    shadow_timer = nxt[7:0];
                end
            end
            drt_pkg::OP_WR_CTRL:
            begin
                if ((wd & drt_pkg::KEY_BYTE_MASK) == drt_pkg::KEY_BYTE_VALUE)
                begin
                    shadow_ctrl = wd[7:0];
                    r.write_accepted = 1'b1;
                end
            end
            drt_pkg::OP_WR_TC:
            begin
                if ((wd & drt_pkg::KEY_BYTE_MASK) == drt_pkg::KEY_BYTE_VALUE)
                begin
                    shadow_tc = wd[7:0];
                    r.write_accepted = 1'b1;
                end
            end
            default:
            begin
                if ((wd & drt_pkg::KEY_COUNT_MASK) == drt_pkg::KEY_COUNT_VALUE)
                begin
                    shadow_count = wd[9:0];
                    r.write_accepted = 1'b1;
                end
            end
        endcase
        if (op != drt_pkg::OP_TICK)
        begin
            if (r.write_accepted)
                n_keys_ok++;
            else
                n_keys_bad++;
        end
        r.timer_value   = shadow_timer;
        r.count_value   = shadow_count;
        r.control_value = shadow_ctrl;
        return r;
    endfunction

    // Predict the status of every command transfer
    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            if (cur_fixed)
            begin
                void'(advance_refresh(drt_pkg::op_t'(cmd_ch.op), cmd_ch.wdata));
                pending_status.push_back(cur_res);
            end
            else
            begin
                pending_status.push_back(advance_refresh(drt_pkg::op_t'(cmd_ch.op),
                                                         cmd_ch.wdata));
            end
        end
    end

    // Check every status transfer against the oldest prediction
    always @(posedge clk)
    begin : status_check
        drt_pkg::result_t want;
        if (rst_n && status_ch.valid && status_ch.ready)
        begin
            if (pending_status.size() == 0)
            begin
                $error("status transfer with no command outstanding");
                errors++;
            end
            else
            begin
                want = pending_status.pop_front();
                n_checked++;
                if (status_ch.timer_value !== want.timer_value)
                begin
                    $error("timer_value: expected %0d, got %0d",
                           want.timer_value, status_ch.timer_value);
                    errors++;
                end
                if (status_ch.count_value !== want.count_value)
                begin
                    $error("count_value: expected %0d, got %0d",
                           want.count_value, status_ch.count_value);
                    errors++;
                end
                if (status_ch.control_value !== want.control_value)
                begin
                    $error("control_value: expected 0x%02h, got 0x%02h",
                           want.control_value, status_ch.control_value);
                    errors++;
                end
                if (status_ch.write_accepted !== want.write_accepted)
                begin
                    $error("write_accepted: expected %0d, got %0d",
                           want.write_accepted, status_ch.write_accepted);
                    errors++;
                end
            end
        end
    end

    // Drive status ready: random idling, plus long hold-offs on request
    initial
    begin : sink_drive
        int hold_left;
        status_ch.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                status_ch.ready = 1'b0;
            end
            else
            begin
                status_ch.ready = !(sink_idle_on && ($urandom_range(0, 99) < 21));
            end
        end
    end

    // Put one command on the bus and hold it until the transfer
    task automatic send_cmd(input drt_pkg::op_t op, input logic [15:0] wd,
                            input bit fixed, input drt_pkg::result_t res);
        @(negedge clk);
        while (src_idle_on && ($urandom_range(0, 99) < 21))
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.op    = op;
        cmd_ch.wdata = wd;
        cur_fixed    = fixed;
        cur_res      = res;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic add_row(input drt_pkg::op_t op, input logic [15:0] wd, input bit fixed,
                           input int t, input int c, input int k, input bit a);
        walk_row_t row;
        row.op                 = op;
        row.wdata              = wd;
        row.fixed              = fixed;
        row.res.timer_value    = t[7:0];
        row.res.count_value    = c[9:0];
        row.res.control_value  = k[7:0];
        row.res.write_accepted = a;
        walk.push_back(row);
    endtask

    // Pick a random command: mostly ticks and well-keyed writes
    function automatic void pick_cmd(output drt_pkg::op_t op, output logic [15:0] wd);
        int          r;
        int          pick;
        logic [9:0]  cnt;
        logic [7:0]  low;
        r  = $urandom_range(0, 99);
        wd = 16'($urandom);
        if (r < 62)
        begin
            op = drt_pkg::OP_TICK;
        end
        else if (r < 95)
        begin
            op = drt_pkg::op_t'($urandom_range(1, 3));
            if ($urandom_range(0, 99) < 85)
            begin
                case (op)
                    drt_pkg::OP_WR_TC:
                    begin
                        if ($urandom_range(0, 99) < 80)
                            low = 8'($urandom_range(0, 12));
                        else
                            low = 8'($urandom);
                        wd = drt_pkg::KEY_BYTE_VALUE | {8'd0, low};
                    end
                    drt_pkg::OP_WR_COUNT:
                    begin
                        pick = $urandom_range(0, 2);
                        if (pick == 0)
                            cnt = 10'($urandom);
                        else if (pick == 1)
                            cnt = 10'($urandom_range(1012, 1023));
                        else
                            cnt = 10'($urandom_range(500, 520));
                        wd = drt_pkg::KEY_COUNT_VALUE | {6'd0, cnt};
                    end
                    default:
                    begin
                        low = 8'($urandom);
                        wd  = drt_pkg::KEY_BYTE_VALUE | {8'd0, low};
                    end
                endcase
            end
        end
        else
        begin
            op = drt_pkg::op_t'($urandom_range(0, 3));
        end
    endfunction

    // Run a stretch of random commands, with an optional status hold-off
    task automatic run_random(input int n, input int hold_at);
        drt_pkg::op_t     op;
        logic [15:0]      wd;
        drt_pkg::result_t none;
        none = '0;
        for (int i = 0; i < n; i++)
        begin
            if (i == hold_at)
                hold_requests++;
            pick_cmd(op, wd);
            send_cmd(op, wd, 1'b0, none);
        end
    endtask

    // Hold the command side until every status has come back
    task automatic drain_status();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
    endtask

    // Main sequence
    initial
    begin : main_seq
        rst_n         = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.op     = drt_pkg::OP_TICK;
        cmd_ch.wdata  = 16'd0;
        cur_fixed     = 1'b0;
        cur_res       = '0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        hold_requests = 0;
        hold_served   = 0;
        errors        = 0;
        n_ticks       = 0;
        n_keys_ok     = 0;
        n_keys_bad    = 0;
        n_wraps       = 0;
        n_checked     = 0;
        shadow_timer  = 8'd0;
        shadow_tc     = 8'd0;
        shadow_count  = 10'd0;
        shadow_ctrl   = 8'd0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk: keys, limits, flag writes, zero and low time constants
        add_row(drt_pkg::OP_TICK,     16'h0000, 1, 0,    1, 8'h80, 0); // zero constant matches
        add_row(drt_pkg::OP_WR_CTRL,  16'hA4FF, 1, 0,    1, 8'h80, 0); // wrong key
        add_row(drt_pkg::OP_WR_CTRL,  16'hA500, 1, 0,    1, 8'h00, 1); // clear both flags
        add_row(drt_pkg::OP_WR_TC,    16'hA5FF, 1, 0,    1, 8'h00, 1);
        add_row(drt_pkg::OP_TICK,     16'hFFFF, 1, 1,    1, 8'h00, 0);
        add_row(drt_pkg::OP_WR_COUNT, 16'hA800, 1, 1,    1, 8'h00, 0); // wrong key
        add_row(drt_pkg::OP_WR_COUNT, 16'hA7FF, 1, 1, 1023, 8'h00, 1);
        add_row(drt_pkg::OP_WR_TC,    16'hA501, 1, 1, 1023, 8'h00, 1); // constant equal to timer
        add_row(drt_pkg::OP_TICK,     16'h0000, 1, 0,    0, 8'h84, 0); // full-range wrap
        add_row(drt_pkg::OP_WR_CTRL,  16'hA5FF, 1, 0,    0, 8'hFF, 1);
        add_row(drt_pkg::OP_WR_COUNT, 16'hA5FF, 1, 0,  511, 8'hFF, 1);
        add_row(drt_pkg::OP_TICK,     16'h0000, 1, 0,    0, 8'hFF, 0); // half-range wrap
        add_row(drt_pkg::OP_WR_CTRL,  16'hA501, 1, 0,    0, 8'h01, 1);
        add_row(drt_pkg::OP_WR_COUNT, 16'hA7FF, 1, 0, 1023, 8'h01, 1); // count above limit
        add_row(drt_pkg::OP_TICK,     16'h0000, 1, 0,    0, 8'h85, 0);
        add_row(drt_pkg::OP_WR_TC,    16'hA500, 1, 0,    0, 8'h85, 1);
        add_row(drt_pkg::OP_TICK,     16'h0000, 1, 0,    1, 8'h85, 0);
        add_row(drt_pkg::OP_WR_TC,    16'hA5FF, 0, 0,    0, 0,     0);
        add_row(drt_pkg::OP_TICK,     16'h5555, 0, 0,    0, 0,     0);
        add_row(drt_pkg::OP_TICK,     16'hAAAA, 0, 0,    0, 0,     0);
        add_row(drt_pkg::OP_TICK,     16'h0000, 0, 0,    0, 0,     0);
        add_row(drt_pkg::OP_WR_TC,    16'hA502, 0, 0,    0, 0,     0);
        add_row(drt_pkg::OP_TICK,     16'h0000, 0, 0,    0, 0,     0);
        add_row(drt_pkg::OP_WR_CTRL,  16'hFFFF, 0, 0,    0, 0,     0);
        add_row(drt_pkg::OP_WR_COUNT, 16'h0000, 0, 0,    0, 0,     0);
        foreach (walk[i])
            send_cmd(walk[i].op, walk[i].wdata, walk[i].fixed, walk[i].res);

        // Random traffic with idling, a status hold-off, then a drain pause
        run_random(450, 200);
        drain_status();

        // Long stretch with no idling on either side
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_random(450, -1);

        // Idling again, with another hold-off
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        run_random(450, 120);

        drain_status();
        repeat (8) @(posedge clk);

        $display("Checked %0d statuses: %0d ticks, %0d count wraps,", n_checked,
                 n_ticks, n_wraps);
        $display("%0d keyed writes taken and %0d refused.", n_keys_ok, n_keys_bad);
        if (errors == 0)
            $display("tb_dram_refresh_timer: PASS");
        else
            $display("tb_dram_refresh_timer: FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #500us;
        $display("tb_dram_refresh_timer: FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/drt_pkg.sv
hw/rtl/drt_cmd_if.sv
hw/rtl/drt_status_if.sv
hw/rtl/drt_core.sv
hw/rtl/dram_refresh_timer.sv
sim/tb_dram_refresh_timer.sv
